// ===== sv/section_latency_stats_table_assert.svh =====
// assertion macros for the section statistics table rtl, used by slst_update
// expects clk and arst_n in the scope of each use
`ifndef SECTION_LATENCY_STATS_TABLE_ASSERT_SVH
`define SECTION_LATENCY_STATS_TABLE_ASSERT_SVH

// condition implies consequence in the same cycle
`define SLST_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define SLST_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/slst_pkg.sv =====
// shared types and constants of the section latency statistics table
// no dependencies
`timescale 1ns / 1ps

package slst_pkg;

	// defaults of the top level parameters
	localparam int SECTIONS_DEF  = 16;
	localparam int TIME_BITS_DEF = 48;

	// fixed field widths
	localparam int OPCODE_W  = 2;
	localparam int SECTION_W = 4;
	localparam int STAMP_W   = 48;
	localparam int ELAPSED_W = 48;
	localparam int TOTAL_W   = 56;
	localparam int CALLS_W   = 32;
	localparam int TRIM_W    = 57;

	// reset and limit values
	localparam logic [31:0]        LOW_RESET    = 32'd2147483647;
	localparam logic [TOTAL_W-1:0] SUM_MAX      = '1;
	localparam logic [CALLS_W-1:0] CALL_MAX     = '1;
	localparam logic [CALLS_W-1:0] ENOUGH_CALLS = 32'd5;

	typedef enum logic [OPCODE_W-1:0] {
		OP_BEGIN = 2'd0,
		OP_END   = 2'd1,
		OP_RESET = 2'd2,
		OP_READ  = 2'd3
	} opcode_t;

	typedef enum logic {
		STATUS_OK       = 1'b0,
		STATUS_NOT_OPEN = 1'b1
	} status_t;

	// statistics of one section after the operation, extremes kept mod 2^57
	typedef struct packed {
		status_t              status;
		logic [ELAPSED_W-1:0] elapsed;
		logic [TOTAL_W-1:0]   total;
		logic [CALLS_W-1:0]   calls;
		logic [TRIM_W-1:0]    low_first;
		logic [TRIM_W-1:0]    low_second;
		logic [TRIM_W-1:0]    high_first;
		logic [TRIM_W-1:0]    high_second;
	} stats_t;

endpackage

// ===== sv/slst_if.sv =====
// request and response channels of the section latency statistics table
// depends on slst_pkg
`timescale 1ns / 1ps

interface slst_req_if;
	logic                           valid;
	logic                           ready;
	logic [slst_pkg::OPCODE_W-1:0]  opcode;
	logic [slst_pkg::SECTION_W-1:0] section;
	logic [slst_pkg::STAMP_W-1:0]   timestamp;

	modport source (output valid, opcode, section, timestamp, input ready);
	modport sink (input valid, opcode, section, timestamp, output ready);
endinterface

interface slst_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                status;
	logic [slst_pkg::ELAPSED_W-1:0]      elapsed;
	logic [slst_pkg::TOTAL_W-1:0]        total_ticks;
	logic [slst_pkg::CALLS_W-1:0]        call_count;
	logic [slst_pkg::ELAPSED_W-1:0]      smallest;
	logic [slst_pkg::ELAPSED_W-1:0]      second_smallest;
	logic [slst_pkg::ELAPSED_W-1:0]      largest;
	logic [slst_pkg::ELAPSED_W-1:0]      second_largest;
	logic signed [slst_pkg::TRIM_W-1:0]  trimmed_sum;
	logic                                enough_data;

	modport source (output valid, status, elapsed, total_ticks, call_count, smallest,
		second_smallest, largest, second_largest, trimmed_sum, enough_data, input ready);
	modport sink (input valid, status, elapsed, total_ticks, call_count, smallest,
		second_smallest, largest, second_largest, trimmed_sum, enough_data, output ready);
endinterface

// ===== sv/slst_update.sv =====
// request register, section table and single pass read-modify-write update
// depends on slst_pkg, slst_if and section_latency_stats_table_assert.svh
`timescale 1ns / 1ps

module slst_update #(
	parameter int SECTIONS  = slst_pkg::SECTIONS_DEF,
	parameter int TIME_BITS = slst_pkg::TIME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	slst_req_if.sink         req,
	output logic             valid_s2,
	input  logic             ready_s2,
	output slst_pkg::stats_t stats_s2
);
	import slst_pkg::*;

	localparam int IDX_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int EW    = TIME_BITS;
	localparam int XW    = (TIME_BITS > 32) ? TIME_BITS : 32;
	localparam int SW    = ((TIME_BITS > TOTAL_W) ? TIME_BITS : TOTAL_W) + 1;

	logic                 valid_s1;
	opcode_t              op_s1;
	logic [SECTION_W-1:0] sec_s1;
	logic [STAMP_W-1:0]   ts_s1;
	logic                 fire1;

	logic [SECTIONS-1:0]  open_q;
	logic [EW-1:0]        start_q [SECTIONS];
	logic [TOTAL_W-1:0]   sum_q   [SECTIONS];
	logic [CALLS_W-1:0]   calls_q [SECTIONS];
	logic [XW-1:0]        lf_q    [SECTIONS];
	logic [XW-1:0]        ls_q    [SECTIONS];
	logic [XW-1:0]        hf_q    [SECTIONS];
	logic [XW-1:0]        hs_q    [SECTIONS];

	logic                       sec_ok;
	logic [IDX_W+SECTION_W-1:0] sec_wide;
	logic [IDX_W-1:0]           idx;
	logic                       rd_open;
	logic [EW-1:0]              rd_start;
	logic [TOTAL_W-1:0]         rd_sum;
	logic [CALLS_W-1:0]         rd_calls;
	logic [XW-1:0]              rd_lf, rd_ls, rd_hf, rd_hs;

	logic [EW-1:0]      ts_e;
	logic [EW-1:0]      e;
	logic [XW-1:0]      e_x;
	logic [SW-1:0]      sum_add;
	logic               end_ok;
	logic [TOTAL_W-1:0] new_sum;
	logic [CALLS_W-1:0] new_calls;
	logic [XW-1:0]      new_lf, new_ls, new_hf, new_hs;

	status_t            p_status;
	logic [EW-1:0]      p_elapsed;
	logic [TOTAL_W-1:0] p_sum;
	logic [CALLS_W-1:0] p_calls;
	logic [XW-1:0]      p_lf, p_ls, p_hf, p_hs;
	stats_t             stats_nxt;

	// stage handshake
	assign fire1     = valid_s1 && (!valid_s2 || ready_s2);
	assign req.ready = !valid_s1 || fire1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1  <= opcode_t'(req.opcode);
			sec_s1 <= req.section;
			ts_s1  <= req.timestamp;
		end
	end

	// section decode and table read
	assign sec_ok   = 32'(sec_s1) < SECTIONS;
	assign sec_wide = {{IDX_W{1'b0}}, sec_s1};
	assign idx      = sec_ok ? sec_wide[IDX_W-1:0] : '0;

	assign rd_open  = open_q[idx];
	assign rd_start = start_q[idx];
	assign rd_sum   = sum_q[idx];
	assign rd_calls = calls_q[idx];
	assign rd_lf    = lf_q[idx];
	assign rd_ls    = ls_q[idx];
	assign rd_hf    = hf_q[idx];
	assign rd_hs    = hs_q[idx];

	// elapsed ticks, wrapping at the timer width
	assign ts_e   = EW'(ts_s1);
	assign e      = ts_e - rd_start;
	assign e_x    = XW'(e);
	assign end_ok = sec_ok && rd_open;

	// saturating total and count
	assign sum_add   = SW'(rd_sum) + SW'(e);
	assign new_sum   = (|sum_add[SW-1:TOTAL_W]) ? SUM_MAX : sum_add[TOTAL_W-1:0];
	assign new_calls = (rd_calls == CALL_MAX) ? rd_calls : rd_calls + 1'b1;

	// two largest and two smallest
	always_comb begin
		new_hf = rd_hf;
		new_hs = rd_hs;
		new_lf = rd_lf;
		new_ls = rd_ls;
		if (e_x > rd_hf) begin
			new_hf = e_x;
			new_hs = rd_hf;
		end else if (e_x > rd_hs) begin
			new_hs = e_x;
		end
		if (e_x < rd_lf) begin
			new_lf = e_x;
			new_ls = rd_lf;
		end else if (e_x < rd_ls) begin
			new_ls = e_x;
		end
	end

	// statistics of the addressed section after the operation
	always_comb begin
		p_status  = STATUS_OK;
		p_elapsed = '0;
		p_sum     = rd_sum;
		p_calls   = rd_calls;
		p_lf      = rd_lf;
		p_ls      = rd_ls;
		p_hf      = rd_hf;
		p_hs      = rd_hs;
		case (op_s1)
			OP_END: begin
				if (end_ok) begin
					p_elapsed = e;
					p_sum     = new_sum;
					p_calls   = new_calls;
					p_lf      = new_lf;
					p_ls      = new_ls;
					p_hf      = new_hf;
					p_hs      = new_hs;
				end else begin
					p_status = STATUS_NOT_OPEN;
				end
			end
			OP_RESET: begin
				p_sum   = '0;
				p_calls = '0;
				p_lf    = XW'(LOW_RESET);
				p_ls    = XW'(LOW_RESET);
				p_hf    = '0;
				p_hs    = '0;
			end
			default: begin
			end
		endcase
		if (!sec_ok) begin
			p_sum   = '0;
			p_calls = '0;
			p_lf    = '0;
			p_ls    = '0;
			p_hf    = '0;
			p_hs    = '0;
		end
	end

	assign stats_nxt.status      = p_status;
	assign stats_nxt.elapsed     = ELAPSED_W'(p_elapsed);
	assign stats_nxt.total       = p_sum;
	assign stats_nxt.calls       = p_calls;
	assign stats_nxt.low_first   = TRIM_W'(p_lf);
	assign stats_nxt.low_second  = TRIM_W'(p_ls);
	assign stats_nxt.high_first  = TRIM_W'(p_hf);
	assign stats_nxt.high_second = TRIM_W'(p_hs);

	// section table write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
			for (int i = 0; i < SECTIONS; i++) begin
				start_q[i] <= '0;
				sum_q[i]   <= '0;
				calls_q[i] <= '0;
				lf_q[i]    <= XW'(LOW_RESET);
				ls_q[i]    <= XW'(LOW_RESET);
				hf_q[i]    <= '0;
				hs_q[i]    <= '0;
			end
		end else if (fire1) begin
			case (op_s1)
				OP_BEGIN: begin
					if (sec_ok) begin
						start_q[idx] <= ts_e;
						open_q[idx]  <= 1'b1;
					end
				end
				OP_END: begin
					if (end_ok) begin
						open_q[idx]  <= 1'b0;
						sum_q[idx]   <= new_sum;
						calls_q[idx] <= new_calls;
						lf_q[idx]    <= new_lf;
						ls_q[idx]    <= new_ls;
						hf_q[idx]    <= new_hf;
						hs_q[idx]    <= new_hs;
					end
				end
				OP_RESET: begin
					open_q <= '0;
					for (int i = 0; i < SECTIONS; i++) begin
						start_q[i] <= '0;
						sum_q[i]   <= '0;
						calls_q[i] <= '0;
						lf_q[i]    <= XW'(LOW_RESET);
						ls_q[i]    <= XW'(LOW_RESET);
						hf_q[i]    <= '0;
						hs_q[i]    <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire1) begin
			valid_s2 <= 1'b1;
		end else if (ready_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			stats_s2 <= stats_nxt;
		end
	end

	`include "section_latency_stats_table_assert.svh"

	`SLST_ASSERT_IMPL(a_extreme_order, valid_s1 && sec_ok, (rd_lf <= rd_ls) && (rd_hs <= rd_hf), "stored extremes out of order")
	`SLST_ASSERT_NEXT(a_end_closes, fire1 && (op_s1 == OP_END) && end_ok, !open_q[$past(idx)], "section still open after end")
	`SLST_ASSERT_NEXT(a_reset_clears, fire1 && (op_s1 == OP_RESET), open_q == '0, "open flags survive reset all")
	`SLST_ASSERT_IMPL(a_fail_no_elapsed, valid_s2 && (stats_s2.status == STATUS_NOT_OPEN), stats_s2.elapsed == '0, "failed end reports elapsed ticks")

endmodule

// ===== sv/slst_report.sv =====
// response stage: trimmed sum, enough-data flag and response register
// depends on slst_pkg and slst_if
`timescale 1ns / 1ps

module slst_report (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s2,
	output logic             ready_s2,
	input  slst_pkg::stats_t stats_s2,
	slst_rsp_if.source       rsp
);
	import slst_pkg::*;

	logic                 fire2;
	logic [TRIM_W-1:0]    low_pair;
	logic [TRIM_W-1:0]    high_pair;
	logic [TRIM_W-1:0]    trim_nxt;

	logic                 valid_s3;
	status_t              status_s3;
	logic [ELAPSED_W-1:0] elapsed_s3;
	logic [TOTAL_W-1:0]   total_s3;
	logic [CALLS_W-1:0]   calls_s3;
	logic [ELAPSED_W-1:0] lf_s3, ls_s3, hf_s3, hs_s3;
	logic [TRIM_W-1:0]    trim_s3;
	logic                 enough_s3;

	// stage handshake
	assign ready_s2 = !valid_s3 || rsp.ready;
	assign fire2    = valid_s2 && ready_s2;

	// total minus both extremes pairs, wrapping at 57 bits
	assign low_pair  = stats_s2.low_first + stats_s2.low_second;
	assign high_pair = stats_s2.high_first + stats_s2.high_second;
	assign trim_nxt  = TRIM_W'(stats_s2.total) - (low_pair + high_pair);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s2) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fire2) begin
			status_s3  <= stats_s2.status;
			elapsed_s3 <= stats_s2.elapsed;
			total_s3   <= stats_s2.total;
			calls_s3   <= stats_s2.calls;
			lf_s3      <= stats_s2.low_first[ELAPSED_W-1:0];
			ls_s3      <= stats_s2.low_second[ELAPSED_W-1:0];
			hf_s3      <= stats_s2.high_first[ELAPSED_W-1:0];
			hs_s3      <= stats_s2.high_second[ELAPSED_W-1:0];
			trim_s3    <= trim_nxt;
			enough_s3  <= stats_s2.calls >= ENOUGH_CALLS;
		end
	end

	// response outputs
	assign rsp.valid           = valid_s3;
	assign rsp.status          = status_s3;
	assign rsp.elapsed         = elapsed_s3;
	assign rsp.total_ticks     = total_s3;
	assign rsp.call_count      = calls_s3;
	assign rsp.smallest        = lf_s3;
	assign rsp.second_smallest = ls_s3;
	assign rsp.largest         = hf_s3;
	assign rsp.second_largest  = hs_s3;
	assign rsp.trimmed_sum     = $signed(trim_s3);
	assign rsp.enough_data     = enough_s3;

endmodule

// ===== sv/section_latency_stats_table.sv =====
// Section latency statistics table.
// req channel: opcode (begin, end, reset all, read), section index and a
// free-running timestamp; every request yields exactly one response on rsp.
// rsp carries status, elapsed ticks of an end, the section's saturating total
// and call count, its two smallest and two largest elapsed values, the
// trimmed sum (total minus those four) and a flag for five or more calls.
// Throughput: one request per cycle, sustained while rsp.ready is high. The
// request register, the result register after the section table
// read-modify-write and the response register form a three register pipeline.
// The table lives in flip-flops and is updated in the same cycle it is
// read, so back to back requests on one section need no forwarding.
// A stalled rsp holds its response; up to two more requests are taken into
// the pipeline, then req.ready drops until rsp.ready returns.
// Reset (arst_n low) clears the pipeline and every section at once: all
// sections closed, totals and counts zero, minima 2147483647, maxima zero.
// Reset all clears the sections likewise, not the pipeline, without stalling.
// depends on slst_pkg, slst_if, slst_update and slst_report
`timescale 1ns / 1ps

module section_latency_stats_table #(
	parameter int SECTIONS  = slst_pkg::SECTIONS_DEF,
	parameter int TIME_BITS = slst_pkg::TIME_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	slst_req_if.sink   req,
	slst_rsp_if.source rsp
);
	import slst_pkg::*;

	logic   valid_s2;
	logic   ready_s2;
	stats_t stats_s2;

	// table lookup and update
	slst_update #(
		.SECTIONS  (SECTIONS),
		.TIME_BITS (TIME_BITS)
	) u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.valid_s2 (valid_s2),
		.ready_s2 (ready_s2),
		.stats_s2 (stats_s2)
	);

	// trimmed sum and response register
	slst_report u_report (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.ready_s2 (ready_s2),
		.stats_s2 (stats_s2),
		.rsp      (rsp)
	);

endmodule

// ===== verif/section_stats_checker.sv =====
// checker for the section latency statistics table: watches both channels,
// keeps its own copy of the section table and compares every response
// depends on slst_pkg and slst_if
`timescale 1ns / 1ps

module section_stats_checker (
	input  logic clk,
	input  logic arst_n,
	slst_req_if  req,
	slst_rsp_if  rsp,
	output int   mismatches,
	output int   outstanding
);
	import slst_pkg::*;

	localparam int NSEC = SECTIONS_DEF;

	// what one response should carry
	typedef struct {
		status_t              status;
		logic [ELAPSED_W-1:0] elapsed;
		logic [TOTAL_W-1:0]   total;
		logic [CALLS_W-1:0]   calls;
		logic [ELAPSED_W-1:0] smallest;
		logic [ELAPSED_W-1:0] second_smallest;
		logic [ELAPSED_W-1:0] largest;
		logic [ELAPSED_W-1:0] second_largest;
		logic [TRIM_W-1:0]    trimmed;
		logic                 enough;
	} section_report_t;

	// shadow of the section table
	bit                   opened    [NSEC];
	logic [STAMP_W-1:0]   began_at  [NSEC];
	logic [TOTAL_W-1:0]   ticks_sum [NSEC];
	logic [CALLS_W-1:0]   ends_seen [NSEC];
	logic [ELAPSED_W-1:0] min1      [NSEC];
	logic [ELAPSED_W-1:0] min2      [NSEC];
	logic [ELAPSED_W-1:0] max1      [NSEC];
	logic [ELAPSED_W-1:0] max2      [NSEC];

	section_report_t expected_reports[$];
	section_report_t want;

	function automatic void clear_table();
		for (int i = 0; i < NSEC; i++) begin
			opened[i]    = 1'b0;
			began_at[i]  = '0;
			ticks_sum[i] = '0;
			ends_seen[i] = '0;
			min1[i]      = ELAPSED_W'(LOW_RESET);
			min2[i]      = ELAPSED_W'(LOW_RESET);
			max1[i]      = '0;
			max2[i]      = '0;
		end
	endfunction

	// apply one request to the shadow table and build its report
	function automatic section_report_t run_request(opcode_t op, logic [SECTION_W-1:0] sec,
		logic [STAMP_W-1:0] stamp);
		section_report_t r;
		logic [ELAPSED_W-1:0] e;
		r.status  = STATUS_OK;
		r.elapsed = '0;
		case (op)
			OP_BEGIN: begin
				began_at[sec] = stamp;
				opened[sec]   = 1'b1;
			end
			OP_END: begin
				if (!opened[sec]) begin
					r.status = STATUS_NOT_OPEN;
				end else begin
					// elapsed wraps modulo the timestamp width
					e = stamp - began_at[sec];
					opened[sec] = 1'b0;
					if (TOTAL_W'(e) > SUM_MAX - ticks_sum[sec])
						ticks_sum[sec] = SUM_MAX;
					else
						ticks_sum[sec] = ticks_sum[sec] + TOTAL_W'(e);
					if (ends_seen[sec] != CALL_MAX)
						ends_seen[sec] = ends_seen[sec] + 1'b1;
					// two largest, replaced one shifts down
					if (e > max1[sec]) begin
						max2[sec] = max1[sec];
						max1[sec] = e;
					end else if (e > max2[sec]) begin
						max2[sec] = e;
					end
					// two smallest
					if (e < min1[sec]) begin
						min2[sec] = min1[sec];
						min1[sec] = e;
					end else if (e < min2[sec]) begin
						min2[sec] = e;
					end
					r.elapsed = e;
				end
			end
			OP_RESET: clear_table();
			default: ;
		endcase
		r.total           = ticks_sum[sec];
		r.calls           = ends_seen[sec];
		r.smallest        = min1[sec];
		r.second_smallest = min2[sec];
		r.largest         = max1[sec];
		r.second_largest  = max2[sec];
		r.trimmed         = TRIM_W'(ticks_sum[sec]) - TRIM_W'(max1[sec]) - TRIM_W'(max2[sec])
			- TRIM_W'(min1[sec]) - TRIM_W'(min2[sec]);
		r.enough          = ends_seen[sec] >= ENOUGH_CALLS;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] exp_val, got_val);
		if (exp_val !== got_val) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s: expected %0h, got %0h", name, exp_val, got_val);
		end
	endtask

	// responses are checked before the request of the same edge is queued
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_table();
			expected_reports.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("response with no request outstanding");
				end else begin
					want = expected_reports.pop_front();
					compare_field("status", 64'(want.status), 64'(rsp.status));
					compare_field("elapsed", 64'(want.elapsed), 64'(rsp.elapsed));
					compare_field("total_ticks", 64'(want.total), 64'(rsp.total_ticks));
					compare_field("call_count", 64'(want.calls), 64'(rsp.call_count));
					compare_field("smallest", 64'(want.smallest), 64'(rsp.smallest));
					compare_field("second_smallest", 64'(want.second_smallest),
						64'(rsp.second_smallest));
					compare_field("largest", 64'(want.largest), 64'(rsp.largest));
					compare_field("second_largest", 64'(want.second_largest),
						64'(rsp.second_largest));
					compare_field("trimmed_sum", {7'd0, want.trimmed}, {7'd0, rsp.trimmed_sum});
					compare_field("enough_data", 64'(want.enough), 64'(rsp.enough_data));
				end
			end
			if (req.valid && req.ready)
				expected_reports.push_back(run_request(opcode_t'(req.opcode), req.section,
					req.timestamp));
			outstanding = expected_reports.size();
		end
	end

endmodule

// ===== verif/section_latency_stats_table_tb.sv =====
// testbench top for the section latency statistics table: clock, reset,
// request stimulus, response back-pressure and the final verdict
// depends on slst_pkg, slst_if, the table rtl and section_stats_checker
`timescale 1ns / 1ps

module section_latency_stats_table_tb;
	import slst_pkg::*;

	localparam int STALL_LIMIT      = 2000;
	localparam int RANDOM_ITEMS     = 70;
	localparam int SATURATION_PAIRS = 260;
	localparam int HOLD_CYCLES      = 120;

	logic        clk;
	logic        arst_n;
	bit          steady;
	int          mismatches;
	int          outstanding;
	int          quiet_cycles;
	logic [15:0] open_map;
	logic [47:0] now_ts;

	slst_req_if req_ch ();
	slst_rsp_if rsp_ch ();

	section_latency_stats_table DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	section_stats_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [47:0] rand_stamp();
		return {16'($urandom), $urandom};
	endfunction

	// free-running tick counter, mostly small steps, sometimes jumps
	function automatic logic [47:0] advance_clock();
		case ($urandom_range(9))
			0: now_ts = rand_stamp();
			1: now_ts = now_ts + 48'($urandom);
			default: now_ts = now_ts + 48'($urandom_range(2000));
		endcase
		return now_ts;
	endfunction

	// offer one request, with random idle cycles ahead of it unless steady is set
	task automatic send(input opcode_t op, input logic [3:0] sec, input logic [47:0] stamp);
		if (!steady) begin
			while ($urandom_range(99) < 19) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_ch.valid     <= 1'b1;
		req_ch.opcode    <= op;
		req_ch.section   <= sec;
		req_ch.timestamp <= stamp;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// response side: random stalls, two long hold-offs, one steady stretch
	initial begin : rsp_side
		int taken;
		int hold_left;
		taken     = 0;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				taken++;
				if (taken == 30 || taken == 450)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (taken >= 150 && taken < 260) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= 19);
			end
		end
	end

	// watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// stimulus and verdict
	initial begin : stimulus
		int r;
		logic [3:0] s;
		logic [47:0] stamp;
		arst_n           = 1'b0;
		steady           = 1'b0;
		quiet_cycles     = 0;
		open_map         = '0;
		now_ts           = '0;
		req_ch.valid     = 1'b0;
		req_ch.opcode    = '0;
		req_ch.section   = '0;
		req_ch.timestamp = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fresh values, closed end, zero and full-range elapsed
		send(OP_READ, 4'd0, '0);
		send(OP_END, 4'd3, '1);
		send(OP_BEGIN, 4'd0, 48'd0);
		send(OP_END, 4'd0, 48'd0);
		send(OP_BEGIN, 4'd0, 48'd1);
		send(OP_END, 4'd0, 48'd0);
		// restart of an open section, then end twice
		send(OP_BEGIN, 4'd0, 48'd100);
		send(OP_BEGIN, 4'd0, 48'd200);
		send(OP_END, 4'd0, 48'd250);
		send(OP_END, 4'd0, 48'd300);
		// counter wrap between begin and end
		send(OP_BEGIN, 4'd0, 48'hFFFF_FFFF_FFF6);
		send(OP_END, 4'd0, 48'd5);
		// tie with a stored extreme, then one above the minimum reset value
		send(OP_BEGIN, 4'd0, 48'd1000);
		send(OP_END, 4'd0, 48'd1050);
		send(OP_BEGIN, 4'd0, 48'd10);
		send(OP_END, 4'd0, 48'd3000000010);
		send(OP_READ, 4'd0, '1);
		// reset all closes open sections
		send(OP_BEGIN, 4'd15, 48'h5555_5555_5555);
		send(OP_BEGIN, 4'd5, 48'hAAAA_AAAA_AAAA);
		send(OP_RESET, 4'd15, 48'h0123_4567_89AB);
		send(OP_END, 4'd5, 48'hAAAA_AAAA_AAAF);
		send(OP_READ, 4'd0, 48'd0);
		send(OP_END, 4'd15, '1);

		// near full-range measurements on one section until the total saturates
		for (int i = 0; i < SATURATION_PAIRS; i++) begin
			steady = (i >= 60 && i < 160);
			stamp = rand_stamp();
			send(OP_BEGIN, 4'd9, stamp);
			send(OP_END, 4'd9, stamp - 48'($urandom_range(1, 1000)));
			if (i % 32 == 0)
				send(OP_READ, 4'd9, rand_stamp());
		end
		steady = 1'b0;
		send(OP_READ, 4'd9, '0);

		// random traffic, mostly begin/end pairs on open sections
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(99);
			s = 4'($urandom_range(15));
			if (r < 40) begin
				open_map[s] = 1'b1;
				send(OP_BEGIN, s, advance_clock());
			end else if (r < 75) begin
				if (open_map != '0)
					while (!open_map[s]) s = s + 1'b1;
				open_map[s] = 1'b0;
				send(OP_END, s, advance_clock());
			end else if (r < 80) begin
				open_map[s] = 1'b0;
				send(OP_END, s, rand_stamp());
			end else if (r < 97) begin
				send(OP_READ, s, rand_stamp());
			end else begin
				open_map = '0;
				send(OP_RESET, s, rand_stamp());
			end
		end
		steady = 1'b0;
		req_ch.valid <= 1'b0;

		// drain, then let the pipeline settle
		@(posedge clk);
		wait (outstanding == 0);
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/slst_pkg.sv
sv/slst_if.sv
sv/slst_update.sv
sv/slst_report.sv
sv/section_latency_stats_table.sv
verif/section_stats_checker.sv
verif/section_latency_stats_table_tb.sv
